/* rtl/smt_pkg.sv */
// shared constants, codes and types for the sorted multiset table
package smt_pkg;

   // default sizes
   localparam int DEFAULT_CAPACITY    = 64;
   localparam int DEFAULT_KEY_WIDTH   = 32;
   localparam int DEFAULT_COUNT_WIDTH = 16;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_COUNT  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_FULL         = 2'd1;
   localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PROBE,
      ST_SHIFT,
      ST_INSERT,
      ST_GET_DATA,
      ST_RESPOND
   } smt_state_type;

endpackage

/* rtl/sorted_multiset_table_unit.sv */
// top level of the sorted multiset table with occurrence counts
//
// Keeps up to CAPACITY distinct keys in ascending order, each with a count.
// req channel (valid/stall): operation, key, position_in. One transaction is
// worked on at a time; req_stall is high while the controller is busy.
// rsp channel (valid/stall): position, key_out, count_out, found, status.
// The result sits in an output register, so the next request is taken
// while a finished response still waits on rsp_stall; the controller only
// holds in its respond state when a second result would overwrite it.
// csr channel (valid/ready): key_order_signed, 0 unsigned, 1 two's complement.
// Work per operation, all through the single entry ram with its registered read:
//   get: one ram read of the requested position, when it is in range
//   count, insert of a present key: a binary search of at most
//     ceil(log2(occupancy + 1)) probes, one ram read each
//   insert of a new key: the count search, then a shift of (occupancy - slot)
//     entries, one entry moved per cycle, then the write of the new key
// The next request is accepted in the cycle the response turns valid.
// Reset (synchronous) empties the table and clears the key order; ram
// contents are left as they are, nothing past the occupancy is ever read.
module sorted_multiset_table_unit #(
   parameter int CAPACITY    = smt_pkg::DEFAULT_CAPACITY,
   parameter int KEY_WIDTH   = smt_pkg::DEFAULT_KEY_WIDTH,
   parameter int COUNT_WIDTH = smt_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [KEY_WIDTH-1:0]          req_key,
   input  logic [$clog2(CAPACITY)-1:0]   req_position_in,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [$clog2(CAPACITY)-1:0]   rsp_position,
   output logic [KEY_WIDTH-1:0]          rsp_key_out,
   output logic [COUNT_WIDTH-1:0]        rsp_count_out,
   output logic                          rsp_found,
   output logic [1:0]                    rsp_status,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_key_order_signed
);

   import smt_pkg::*;

   localparam int POS_W   = $clog2(CAPACITY);
   localparam int OCC_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = KEY_WIDTH + COUNT_WIDTH;

   // control state
   smt_state_type            state_ff, state_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic                     signed_ff, signed_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // transaction context
   logic [1:0]               op_ff, op_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [OCC_W-1:0]         lo_ff, lo_in;
   logic [OCC_W-1:0]         hi_ff, hi_in;
   logic [OCC_W-1:0]         mid_ff, mid_in;
   logic                     hit_ff, hit_in;
   logic [COUNT_WIDTH-1:0]   hit_count_ff, hit_count_in;
   logic [OCC_W-1:0]         cnt_ff, cnt_in;
   logic [POS_W-1:0]         wr_idx_ff, wr_idx_in;

   // staged result
   logic [POS_W-1:0]         res_position_ff, res_position_in;
   logic [KEY_WIDTH-1:0]     res_key_ff, res_key_in;
   logic [COUNT_WIDTH-1:0]   res_count_ff, res_count_in;
   logic                     res_found_ff, res_found_in;
   logic [1:0]               res_status_ff, res_status_in;

   // output register
   logic [POS_W-1:0]         rsp_position_ff, rsp_position_in;
   logic [KEY_WIDTH-1:0]     rsp_key_ff, rsp_key_in;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   // ram port signals
   logic                     ram_we;
   logic [POS_W-1:0]         ram_waddr;
   logic [ENTRY_W-1:0]       ram_wdata;
   logic [POS_W-1:0]         ram_raddr;
   logic [ENTRY_W-1:0]       ram_rdata;

   // datapath helpers
   logic [KEY_WIDTH-1:0]     rd_key;
   logic [COUNT_WIDTH-1:0]   rd_count;
   logic [KEY_WIDTH-1:0]     key_flip;
   logic [KEY_WIDTH-1:0]     rd_order;
   logic [KEY_WIDTH-1:0]     key_order;
   logic [OCC_W:0]           mid_sum;
   logic [OCC_W-1:0]         mid;
   logic [OCC_W-1:0]         shift_src;
   logic [OCC_W-1:0]         shift_dst;
   logic [COUNT_WIDTH-1:0]   count_inc;

   // entry storage: key in the upper bits, count in the lower bits
   smt_ram #(
      .DATA_WIDTH (ENTRY_W),
      .DEPTH      (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_key   = ram_rdata[ENTRY_W-1:COUNT_WIDTH];
   assign rd_count = ram_rdata[COUNT_WIDTH-1:0];

   // signed order flips the sign bit so an unsigned compare gives the order
   assign key_flip  = {signed_ff, {(KEY_WIDTH-1){1'b0}}};
   assign rd_order  = rd_key ^ key_flip;
   assign key_order = key_ff ^ key_flip;

   // binary search midpoint
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[OCC_W:1];

   // shift move addresses, highest entry first
   assign shift_src = lo_ff + cnt_ff - OCC_W'(1);
   assign shift_dst = shift_src + OCC_W'(1);

   // saturating count increment
   assign count_inc = (hit_count_ff == {COUNT_WIDTH{1'b1}}) ? hit_count_ff
                                                            : hit_count_ff + COUNT_WIDTH'(1);

   // handshake outputs
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // next state and datapath control
   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      signed_in       = signed_ff;
      pend_in         = 1'b0;
      rsp_valid_in    = rsp_valid_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      hit_in          = hit_ff;
      hit_count_in    = hit_count_ff;
      cnt_in          = cnt_ff;
      wr_idx_in       = wr_idx_ff;
      res_position_in = res_position_ff;
      res_key_in      = res_key_ff;
      res_count_in    = res_count_ff;
      res_found_in    = res_found_ff;
      res_status_in   = res_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_key_in      = rsp_key_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_status_in   = rsp_status_ff;
      ram_we          = 1'b0;
      ram_waddr       = wr_idx_ff;
      ram_wdata       = ram_rdata;
      ram_raddr       = '0;

      // configuration write
      if (csr_valid) begin
         signed_in = csr_key_order_signed;
      end

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in           = req_operation;
               key_in          = req_key;
               lo_in           = '0;
               hi_in           = occ_ff;
               hit_in          = 1'b0;
               hit_count_in    = '0;
               res_position_in = '0;
               res_key_in      = '0;
               res_count_in    = '0;
               res_found_in    = 1'b0;
               res_status_in   = STATUS_OK;
               case (req_operation)
                  OP_INSERT, OP_COUNT: begin
                     state_in = ST_SEARCH;
                  end
                  OP_GET: begin
                     if (OCC_W'(req_position_in) < occ_ff) begin
                        ram_raddr = req_position_in;
                        state_in  = ST_GET_DATA;
                     end else begin
                        res_status_in = STATUS_OUT_OF_RANGE;
                        state_in      = ST_RESPOND;
                     end
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end

         // lower bound search over the occupied entries
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = mid[POS_W-1:0];
               mid_in    = mid;
               state_in  = ST_PROBE;
            end else if (op_ff == OP_COUNT) begin
               res_count_in = hit_ff ? hit_count_ff : '0;
               res_found_in = hit_ff;
               state_in     = ST_RESPOND;
            end else if (hit_ff) begin
               ram_we          = 1'b1;
               ram_waddr       = lo_ff[POS_W-1:0];
               ram_wdata       = {key_ff, count_inc};
               res_position_in = lo_ff[POS_W-1:0];
               res_found_in    = 1'b1;
               state_in        = ST_RESPOND;
            end else if (occ_ff == OCC_W'(CAPACITY)) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_RESPOND;
            end else begin
               res_position_in = lo_ff[POS_W-1:0];
               cnt_in          = occ_ff - lo_ff;
               state_in        = ST_SHIFT;
            end
         end

         // compare the probed entry and narrow the range
         ST_PROBE: begin
            if (rd_order < key_order) begin
               lo_in = mid_ff + OCC_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            if (rd_order == key_order) begin
               hit_in       = 1'b1;
               hit_count_in = rd_count;
            end
            state_in = ST_SEARCH;
         end

         // move entries up by one, read and write overlapped
         ST_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_idx_ff;
               ram_wdata = ram_rdata;
            end
            if (cnt_ff != '0) begin
               ram_raddr = shift_src[POS_W-1:0];
               wr_idx_in = shift_dst[POS_W-1:0];
               pend_in   = 1'b1;
               cnt_in    = cnt_ff - OCC_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_INSERT;
            end
         end

         // place the new key with a count of one
         ST_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff[POS_W-1:0];
            ram_wdata = {key_ff, COUNT_WIDTH'(1)};
            occ_in    = occ_ff + OCC_W'(1);
            state_in  = ST_RESPOND;
         end

         ST_GET_DATA: begin
            res_key_in   = rd_key;
            res_found_in = 1'b1;
            state_in     = ST_RESPOND;
         end

         // hand the result to the output register once it is free
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = res_position_ff;
               rsp_key_in      = res_key_ff;
               rsp_count_in    = res_count_ff;
               rsp_found_in    = res_found_ff;
               rsp_status_in   = res_status_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         signed_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         signed_ff    <= signed_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      hit_ff          <= hit_in;
      hit_count_ff    <= hit_count_in;
      cnt_ff          <= cnt_in;
      wr_idx_ff       <= wr_idx_in;
      res_position_ff <= res_position_in;
      res_key_ff      <= res_key_in;
      res_count_ff    <= res_count_in;
      res_found_ff    <= res_found_in;
      res_status_ff   <= res_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_key_ff      <= rsp_key_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* rtl/smt_ram.sv */
// generic simple dual port ram with registered read
module smt_ram #(
   parameter int DATA_WIDTH = 48,
   parameter int DEPTH      = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/smt_checker.sv */
// port level checks for the sorted multiset table, bound to the top level
module smt_checker #(
   parameter int CAPACITY    = smt_pkg::DEFAULT_CAPACITY,
   parameter int KEY_WIDTH   = smt_pkg::DEFAULT_KEY_WIDTH,
   parameter int COUNT_WIDTH = smt_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [$clog2(CAPACITY)-1:0]   rsp_position,
   input  logic [KEY_WIDTH-1:0]          rsp_key_out,
   input  logic [COUNT_WIDTH-1:0]        rsp_count_out,
   input  logic                          rsp_found,
   input  logic [1:0]                    rsp_status
);

   import smt_pkg::*;

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) &&
         $stable(rsp_key_out) && $stable(rsp_count_out) &&
         $stable(rsp_found) && $stable(rsp_status))
      else $error("stalled response changed");

   // a rejected insert reports no found flag, position or count
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         !rsp_found && rsp_position == '0 && rsp_count_out == '0)
      else $error("full status with other fields set");

   // an out of range get returns no key
   a_range_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OUT_OF_RANGE |->
         !rsp_found && rsp_key_out == '0)
      else $error("out of range status with key or found set");

   // a found entry never comes with an error status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
      else $error("found with error status");

endmodule

bind sorted_multiset_table_unit smt_checker #(
   .CAPACITY    (CAPACITY),
   .KEY_WIDTH   (KEY_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_smt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_position  (rsp_position),
   .rsp_key_out   (rsp_key_out),
   .rsp_count_out (rsp_count_out),
   .rsp_found     (rsp_found),
   .rsp_status    (rsp_status)
);
